FILE: hdl/lpat_pkg.sv
// shared types and constants for the locked pointer association table
package lpat_pkg;

	localparam int unsigned KEY_W = 64;
	localparam int unsigned VAL_W = 64;

	// operation codes carried by func
	typedef enum logic [0:0] {
		FUNC_REMEMBER = 1'b0,
		FUNC_RECALL   = 1'b1
	} func_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// per entry compare outcome from the shared compare unit
	typedef struct packed {
		logic key_eq;
		logic val_zero;
	} cmp_res_t;

endpackage

FILE: hdl/locked_pointer_assoc_table_unit.sv
// top level of the locked pointer association table: sequencer, result register
//
// A fully associative table of ENTRIES key/value pairs, all zero after reset.
// func 0 (remember) writes the value into the lowest entry whose key matches,
// clearing that entry's key too when the value is zero; with no match it
// places key and value into the lowest entry whose value is zero, or raises
// table_full and leaves the table untouched. func 1 (recall) returns the
// value of the lowest matching entry, or zero with hit low. One result item
// comes out per input item. The entries sit in a memory with separate read and
// write ports that a small sequencer walks one entry per cycle through one
// shared 64-bit compare unit: the item is taken in the idle state, every entry
// is read and its registered read data compared during the scan, and the
// done state writes back and loads the result. The input side stalls while
// an item is in the scan or waits in the done state; a finished result
// waits in the output register and does not block the next item's scan.
module locked_pointer_assoc_table_unit #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic [lpat_pkg::KEY_W-1:0] key,
	input  logic [lpat_pkg::VAL_W-1:0] value,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic [lpat_pkg::VAL_W-1:0] recalled_value,
	output logic                       table_full
);
	import lpat_pkg::*;

	// index width for entry addresses, counter wide enough to hold ENTRIES
	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

	state_t state_q, state_d;

	// latched item
	func_t            func_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	// scan progress
	logic [CNT_W-1:0] cnt_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	// first match and first free entry seen so far
	logic             match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [VAL_W-1:0] match_val_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	// result register
	logic             out_valid_q;
	logic             hit_q;
	logic [VAL_W-1:0] recalled_q;
	logic             full_q;

	// store and compare wiring
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;
	logic             rd_vld;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [KEY_W-1:0] wr_key;
	cmp_res_t         cmp_res;

	logic in_acc;
	logic out_free;
	logic finish;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == ST_DONE) && out_free;

	// issue one entry read per scan cycle
	assign rd_en   = (state_q == ST_SCAN) && (cnt_q < CNT_END);
	assign rd_addr = cnt_q[IDX_W-1:0];

	lpat_store #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_val  (rd_val),
		.rd_vld  (rd_vld),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_val  (value_q)
	);

	lpat_cmp u_cmp (
		.item_key (key_q),
		.ent_key  (rd_key),
		.ent_val  (rd_val),
		.ent_vld  (rd_vld),
		.res      (cmp_res)
	);

	// write back decision: matched entry first, else lowest free entry
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = match_idx_q;
		wr_key  = key_q;
		if (finish && (func_q == FUNC_REMEMBER)) begin
			if (match_found_q) begin
				wr_en   = 1'b1;
				wr_addr = match_idx_q;
				// zero value releases the entry's key
				wr_key  = (value_q == '0) ? '0 : key_q;
			end else if (free_found_q) begin
				wr_en   = 1'b1;
				wr_addr = free_idx_q;
			end
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// last compare lands once the counter has passed every entry
				if (cnt_q == CNT_END) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q  <= func_t'(func);
			key_q   <= key;
			value_q <= value;
		end
	end

	// scan counter, compare stage and lowest-hit tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			cmp_vld_s1    <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (in_acc) begin
				cnt_q         <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
			end else begin
				if (rd_en) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (cmp_vld_s1) begin
					if (cmp_res.key_eq && !match_found_q) begin
						match_found_q <= 1'b1;
					end
					if (cmp_res.val_zero && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cmp_idx_s1 <= rd_addr;
		end
		if (cmp_vld_s1 && cmp_res.key_eq && !match_found_q) begin
			match_idx_q <= cmp_idx_s1;
			match_val_q <= rd_vld ? rd_val : '0;
		end
		if (cmp_vld_s1 && cmp_res.val_zero && !free_found_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q      <= match_found_q;
			recalled_q <= ((func_q == FUNC_RECALL) && match_found_q) ? match_val_q : '0;
			full_q     <= (func_q == FUNC_REMEMBER) && !match_found_q && !free_found_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign recalled_value = recalled_q;
	assign table_full     = full_q;

	// a full table report never comes with a hit
	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(full_q && hit_q))
		else $error("table_full raised together with hit");

	// a nonzero recalled value needs a hit
	a_recall_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (recalled_q != '0)) |-> hit_q)
		else $error("recalled value without hit");

	// the table is only written while the result is being loaded
	a_write_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_DONE) && out_free)
		else $error("table write outside of write back");

	// compare data only follows a scan read
	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> $past(rd_en))
		else $error("compare stage valid without a read");

	// finishing an item returns the sequencer to idle
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("sequencer did not return to idle after write back");

endmodule

FILE: hdl/lpat_store.sv
// key and value memories with per entry valid bits
module lpat_store #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned IDX_W   = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [IDX_W-1:0]           rd_addr,
	output logic [lpat_pkg::KEY_W-1:0] rd_key,
	output logic [lpat_pkg::VAL_W-1:0] rd_val,
	output logic                       rd_vld,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_addr,
	input  logic [lpat_pkg::KEY_W-1:0] wr_key,
	input  logic [lpat_pkg::VAL_W-1:0] wr_val
);
	import lpat_pkg::*;

	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [VAL_W-1:0] val_mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	logic [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0] rd_val_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	// valid bits mark written entries; entries never written read back with rd_vld low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_key = rd_key_q;
	assign rd_val = rd_val_q;
	assign rd_vld = rd_vld_q;

endmodule

FILE: hdl/lpat_cmp.sv
// shared compare unit: key match and free entry test for one entry
module lpat_cmp (
	input  logic [lpat_pkg::KEY_W-1:0] item_key,
	input  logic [lpat_pkg::KEY_W-1:0] ent_key,
	input  logic [lpat_pkg::VAL_W-1:0] ent_val,
	input  logic                       ent_vld,
	output lpat_pkg::cmp_res_t         res
);
	import lpat_pkg::*;

	logic [KEY_W-1:0] eff_key;
	logic [VAL_W-1:0] eff_val;

	// unwritten entry behaves as key zero, value zero
	assign eff_key = ent_vld ? ent_key : '0;
	assign eff_val = ent_vld ? ent_val : '0;

	assign res.key_eq   = (eff_key == item_key);
	assign res.val_zero = (eff_val == '0);

endmodule
